// ===== design/nmea_gsv_pkg.sv =====
// Shared types, character codes and constants of the NMEA GSV satellite SNR parser.
package nmea_gsv_pkg;

  localparam logic KindEntry   = 1'b0;
  localparam logic KindSummary = 1'b1;

  localparam logic [7:0] MaxEntriesReset = 8'd32;

  // Register decode: bit 2 of the byte address selects the register slot.
  localparam logic AddrMaxEntries = 1'b0;

  localparam int ResultDepth = 4;
  localparam int TagLen      = 6;

  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharComma  = 8'h2C;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;

  typedef struct packed {
    logic        kind;
    logic [7:0]  sat_id;
    logic [7:0]  sat_snr;
    logic [63:0] time_ms;
    logic [7:0]  entry_count;
    logic        last_of_run;
  } result_t;

  // Characters of the "$GPGSV" tag, by match position.
  function automatic logic [7:0] tag_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h24;
      3'd1:    ch = 8'h47;
      3'd2:    ch = 8'h50;
      3'd3:    ch = 8'h47;
      3'd4:    ch = 8'h53;
      3'd5:    ch = 8'h56;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== design/nmea_gsv_satellite_snr_parser.sv =====
// Top level of the NMEA GSV satellite SNR parser: sentence state machine and result queue.
//
// The block takes one character beat per clock cycle unless it stalls: all parsing
// (timestamp times-ten accumulation, tag match, comma skipping, field accumulation)
// is done by short logic in front of the sentence state registers. Results leave
// through a four-entry queue at one beat per cycle while out_stall is low; the
// character that ends a sentence can push two results (a trailing satellite entry
// and the summary), and the queue absorbs the extra beat, so the input stalls
// whenever fewer than two queue slots are free. There is no clearing pass after reset.
module nmea_gsv_satellite_snr_parser (
  input  logic        clk,
  input  logic        rst_n,
  // Character input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_in,
  input  logic        in_end_of_sentence,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_sat_id,
  output logic [7:0]  out_sat_snr,
  output logic [63:0] out_time_ms,
  output logic [7:0]  out_entry_count,
  output logic        out_last_of_run,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int Depth  = nmea_gsv_pkg::ResultDepth;
  localparam int PtrW   = $clog2(Depth);
  localparam int CountW = $clog2(Depth + 1);

  typedef enum logic [3:0] {
    PH_TS,
    PH_TAG,
    PH_SKIP3,
    PH_COUNT,
    PH_ID,
    PH_SKIP2,
    PH_SNR0,
    PH_SNRMORE,
    PH_IDLE
  } phase_t;

  // Sentence state.
  phase_t      phase_r, phase_nxt, phase_eff;
  logic [63:0] time_acc_r, time_acc_nxt;
  logic [2:0]  tag_pos_r, tag_pos_nxt;
  logic [1:0]  comma_left_r, comma_left_nxt, comma_dec;
  logic [7:0]  value_acc_r, value_acc_nxt;
  logic [7:0]  held_id_r, held_id_nxt;
  logic [7:0]  emitted_r, emitted_nxt;
  logic [7:0]  max_entries_r;

  // Result queue.
  nmea_gsv_pkg::result_t queue_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CountW-1:0] count_r;

  logic       in_acc, out_acc;
  logic       is_digit;
  logic [3:0] digit;
  logic [7:0] acc_ten;
  logic       emit_try, entry_ok;
  logic [7:0] emit_snr;
  logic [7:0] count_after;
  logic       push_entry, push_summary;
  logic [1:0] push_n;
  nmea_gsv_pkg::result_t entry_res, summary_res;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Keep room for the two results a sentence end can produce.
  assign in_stall  = count_r > CountW'(Depth - 2);
  assign out_valid = count_r != '0;

  assign is_digit = (in_char_in >= nmea_gsv_pkg::CharZero) &&
                    (in_char_in <= nmea_gsv_pkg::CharNine);
  assign digit    = is_digit ? 4'(in_char_in - nmea_gsv_pkg::CharZero) : 4'd0;
  assign acc_ten  = {value_acc_r[4:0], 3'b000} + {value_acc_r[6:0], 1'b0} + {4'd0, digit};
  assign comma_dec = comma_left_r - 2'd1;

  // A non-digit that closes the timestamp is handled as the first tag-search character.
  assign phase_eff = (phase_r == PH_TS && !is_digit) ? PH_TAG : phase_r;

  always_comb begin
    phase_nxt      = phase_eff;
    time_acc_nxt   = time_acc_r;
    tag_pos_nxt    = tag_pos_r;
    comma_left_nxt = comma_left_r;
    value_acc_nxt  = value_acc_r;
    held_id_nxt    = held_id_r;
    emit_try       = 1'b0;
    emit_snr       = value_acc_r;
    case (phase_eff)
      PH_TS: begin
        time_acc_nxt = {time_acc_r[60:0], 3'b000} + {time_acc_r[62:0], 1'b0} +
                       {60'd0, digit};
      end
      PH_TAG: begin
        if (tag_pos_r < 3'(nmea_gsv_pkg::TagLen) &&
            in_char_in == nmea_gsv_pkg::tag_char(tag_pos_r)) begin
          tag_pos_nxt = tag_pos_r + 3'd1;
          if (tag_pos_r == 3'(nmea_gsv_pkg::TagLen - 1)) begin
            phase_nxt      = PH_SKIP3;
            comma_left_nxt = 2'd3;
          end
        end else begin
          tag_pos_nxt = (in_char_in == nmea_gsv_pkg::CharDollar) ? 3'd1 : 3'd0;
        end
      end
      PH_SKIP3, PH_SKIP2: begin
        if (in_char_in == nmea_gsv_pkg::CharStar) begin
          phase_nxt = PH_IDLE;
        end else if (in_char_in == nmea_gsv_pkg::CharComma) begin
          comma_left_nxt = comma_dec;
          if (comma_dec == 2'd0) begin
            phase_nxt     = (phase_eff == PH_SKIP3) ? PH_COUNT : PH_SNR0;
            value_acc_nxt = 8'd0;
          end
        end
      end
      PH_COUNT: begin
        if (is_digit) begin
          value_acc_nxt = acc_ten;
        end else begin
          phase_nxt     = (value_acc_r != 8'd0) ? PH_ID : PH_IDLE;
          value_acc_nxt = 8'd0;
        end
      end
      PH_ID: begin
        if (is_digit) begin
          value_acc_nxt = acc_ten;
        end else begin
          held_id_nxt    = value_acc_r;
          value_acc_nxt  = 8'd0;
          comma_left_nxt = 2'd2;
          phase_nxt      = PH_SKIP2;
        end
      end
      PH_SNR0, PH_SNRMORE: begin
        if (is_digit) begin
          value_acc_nxt = (phase_eff == PH_SNR0) ? {4'd0, digit} : acc_ten;
          phase_nxt     = PH_SNRMORE;
        end else begin
          // An empty SNR field reports zero.
          emit_try      = 1'b1;
          emit_snr      = (phase_eff == PH_SNR0) ? 8'd0 : value_acc_r;
          value_acc_nxt = 8'd0;
          phase_nxt     = PH_ID;
        end
      end
      default: begin
      end
    endcase
    // A sentence that ends after at least one SNR digit still reports its entry.
    if (in_end_of_sentence && phase_nxt == PH_SNRMORE) begin
      emit_try = 1'b1;
      emit_snr = value_acc_nxt;
    end
  end

  assign entry_ok    = emit_try && (held_id_r != 8'd0) && (emitted_r < max_entries_r);
  assign count_after = emitted_r + {7'd0, entry_ok};
  assign emitted_nxt = count_after;

  always_comb begin
    entry_res             = '0;
    entry_res.kind        = nmea_gsv_pkg::KindEntry;
    entry_res.sat_id      = held_id_r;
    entry_res.sat_snr     = emit_snr;
    entry_res.last_of_run = !in_end_of_sentence;
    summary_res             = '0;
    summary_res.kind        = nmea_gsv_pkg::KindSummary;
    summary_res.time_ms     = time_acc_nxt;
    summary_res.entry_count = count_after;
    summary_res.last_of_run = 1'b1;
  end

  assign push_entry   = in_acc && entry_ok;
  assign push_summary = in_acc && in_end_of_sentence;
  assign push_n       = {1'b0, push_entry} + {1'b0, push_summary};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_TS;
      time_acc_r   <= '0;
      tag_pos_r    <= '0;
      comma_left_r <= '0;
      value_acc_r  <= '0;
      held_id_r    <= '0;
      emitted_r    <= '0;
    end else if (in_acc) begin
      if (in_end_of_sentence) begin
        phase_r      <= PH_TS;
        time_acc_r   <= '0;
        tag_pos_r    <= '0;
        comma_left_r <= '0;
        value_acc_r  <= '0;
        held_id_r    <= '0;
        emitted_r    <= '0;
      end else begin
        phase_r      <= phase_nxt;
        time_acc_r   <= time_acc_nxt;
        tag_pos_r    <= tag_pos_nxt;
        comma_left_r <= comma_left_nxt;
        value_acc_r  <= value_acc_nxt;
        held_id_r    <= held_id_nxt;
        emitted_r    <= emitted_nxt;
      end
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PtrW'(push_n);
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
      count_r <= count_r + CountW'(push_n) - CountW'(out_acc);
    end
  end

  // Queue storage; the summary lands behind the entry when both are pushed.
  always_ff @(posedge clk) begin
    if (push_entry) begin
      queue_r[wr_ptr_r] <= entry_res;
    end
    if (push_summary) begin
      queue_r[wr_ptr_r + PtrW'(push_entry)] <= summary_res;
    end
  end

  assign out_kind        = queue_r[rd_ptr_r].kind;
  assign out_sat_id      = queue_r[rd_ptr_r].sat_id;
  assign out_sat_snr     = queue_r[rd_ptr_r].sat_snr;
  assign out_time_ms     = queue_r[rd_ptr_r].time_ms;
  assign out_entry_count = queue_r[rd_ptr_r].entry_count;
  assign out_last_of_run = queue_r[rd_ptr_r].last_of_run;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= nmea_gsv_pkg::MaxEntriesReset;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == nmea_gsv_pkg::AddrMaxEntries) begin
      max_entries_r <= pwdata[7:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == nmea_gsv_pkg::AddrMaxEntries) ? {24'd0, max_entries_r} : 32'd0;

endmodule

// ===== design/nmea_gsv_checker.sv =====
// Port-level assertions for the NMEA GSV satellite SNR parser and their bind.
module nmea_gsv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_kind,
  input logic [7:0]  out_sat_id,
  input logic [63:0] out_time_ms,
  input logic [7:0]  out_entry_count,
  input logic        out_last_of_run
);

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat shown right after reset");

  // A summary always closes its run.
  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == nmea_gsv_pkg::KindSummary |-> out_last_of_run)
    else $error("summary beat not marked last of run");

  // An entry that is not last is followed at once by its summary.
  a_entry_then_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_kind == nmea_gsv_pkg::KindEntry && !out_last_of_run
    |=> out_valid && out_kind == nmea_gsv_pkg::KindSummary)
    else $error("entry beat not followed by its summary");

  // Entries carry a nonzero id and no summary fields.
  a_entry_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == nmea_gsv_pkg::KindEntry
    |-> out_sat_id != 8'd0 && out_time_ms == 64'd0 && out_entry_count == 8'd0)
    else $error("malformed satellite entry beat");

endmodule

bind nmea_gsv_satellite_snr_parser nmea_gsv_checker u_nmea_gsv_checker (.*);

// ===== test/testbench.sv =====
// Testbench for the NMEA GSV parser: directed and random sentences checked against a predictor.
module testbench;

  // Run bounds: the cycle limit is far above the slowest legal run, and the drain
  // wait lets the design settle once every expected result has been seen.
  localparam int CycleLimit    = 400000;
  localparam int DrainCycles   = 8;
  localparam int RandomChars   = 1500;
  localparam int LinesPerLimit = 8;

  // Register slot of max_entries, in byte address form.
  localparam logic [2:0] MaxEntriesAddr = {nmea_gsv_pkg::AddrMaxEntries, 2'b00};

  // The sentence tag the parser hunts for, first character in the top byte.
  localparam logic [47:0] GsvTag = "$GPGSV";

  typedef enum logic [3:0] {
    PhTimestamp,
    PhTag,
    PhSkipHeader,
    PhCount,
    PhId,
    PhSkipGroup,
    PhSnrFirst,
    PhSnrMore,
    PhIgnore
  } parse_phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_in = 8'd0;
  logic        in_end_of_sentence = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [7:0]  out_sat_id;
  logic [7:0]  out_sat_snr;
  logic [63:0] out_time_ms;
  logic [7:0]  out_entry_count;
  logic        out_last_of_run;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  nmea_gsv_satellite_snr_parser uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_char_in         (in_char_in),
    .in_end_of_sentence (in_end_of_sentence),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_sat_id         (out_sat_id),
    .out_sat_snr        (out_sat_snr),
    .out_time_ms        (out_time_ms),
    .out_entry_count    (out_entry_count),
    .out_last_of_run    (out_last_of_run),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idling regime, percent per cycle: send_idle_pct for the driver, recv_stall_pct for the stall generator.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  int error_count = 0;
  int chars_sent = 0;
  int lines_sent = 0;
  int results_checked = 0;
  int limit_writes = 0;
  int cycle_count = 0;

  // Predictor state: one copy of the per-sentence parse state plus the register.
  parse_phase_t ph = PhTimestamp;
  logic [63:0]  ts_acc = 64'd0;
  logic [2:0]   tag_pos = 3'd0;
  logic [1:0]   commas_left = 2'd0;
  logic [7:0]   field_acc = 8'd0;
  logic [7:0]   sat_held = 8'd0;
  logic [7:0]   sent_entries = 8'd0;
  logic [7:0]   entry_limit = nmea_gsv_pkg::MaxEntriesReset;

  nmea_gsv_pkg::result_t step_results[$];
  nmea_gsv_pkg::result_t expected_results[$];
  logic [7:0] line_q[$];

  function automatic void clear_sentence();
    ph = PhTimestamp;
    ts_acc = 64'd0;
    tag_pos = 3'd0;
    commas_left = 2'd0;
    field_acc = 8'd0;
    sat_held = 8'd0;
    sent_entries = 8'd0;
  endfunction

  // A satellite entry leaves only for a nonzero id and while under the limit.
  function automatic void add_entry();
    nmea_gsv_pkg::result_t r;
    if (sat_held != 8'd0 && sent_entries < entry_limit) begin
      r = '0;
      r.kind = nmea_gsv_pkg::KindEntry;
      r.sat_id = sat_held;
      r.sat_snr = field_acc;
      step_results.push_back(r);
      sent_entries = sent_entries + 8'd1;
    end
  endfunction

  // Advances the predicted parse state by one character and queues what it causes.
  function automatic void predict_char(input logic [7:0] ch, input logic last);
    logic                  is_digit;
    logic [7:0]            digit;
    nmea_gsv_pkg::result_t r;
    is_digit = (ch >= nmea_gsv_pkg::CharZero) && (ch <= nmea_gsv_pkg::CharNine);
    digit = is_digit ? ch - nmea_gsv_pkg::CharZero : 8'd0;
    step_results.delete();
    if (ph == PhTimestamp && is_digit) begin
      ts_acc = ts_acc * 64'd10 + 64'(digit);
    end else begin
      if (ph == PhTimestamp) ph = PhTag;
      case (ph)
        PhTag: begin
          if (tag_pos < nmea_gsv_pkg::TagLen &&
              ch == GsvTag[8 * (nmea_gsv_pkg::TagLen - 1 - tag_pos) +: 8]) begin
            tag_pos = tag_pos + 3'd1;
            if (tag_pos == nmea_gsv_pkg::TagLen) begin
              ph = PhSkipHeader;
              commas_left = 2'd3;
            end
          end else begin
            // A stray dollar sign restarts the match one character in.
            tag_pos = (ch == nmea_gsv_pkg::CharDollar) ? 3'd1 : 3'd0;
          end
        end
        PhSkipHeader, PhSkipGroup: begin
          if (ch == nmea_gsv_pkg::CharStar) begin
            ph = PhIgnore;
          end else if (ch == nmea_gsv_pkg::CharComma) begin
            commas_left = commas_left - 2'd1;
            if (commas_left == 2'd0) begin
              ph = (ph == PhSkipHeader) ? PhCount : PhSnrFirst;
              field_acc = 8'd0;
            end
          end
        end
        PhCount: begin
          if (is_digit) begin
            field_acc = field_acc * 8'd10 + digit;
          end else begin
            ph = (field_acc != 8'd0) ? PhId : PhIgnore;
            field_acc = 8'd0;
          end
        end
        PhId: begin
          if (is_digit) begin
            field_acc = field_acc * 8'd10 + digit;
          end else begin
            sat_held = field_acc;
            field_acc = 8'd0;
            commas_left = 2'd2;
            ph = PhSkipGroup;
          end
        end
        PhSnrFirst, PhSnrMore: begin
          if (is_digit) begin
            field_acc = (ph == PhSnrFirst) ? digit : field_acc * 8'd10 + digit;
            ph = PhSnrMore;
          end else begin
            if (ph == PhSnrFirst) field_acc = 8'd0;
            add_entry();
            field_acc = 8'd0;
            ph = PhId;
          end
        end
        default: ;
      endcase
    end
    if (last) begin
      // A sentence cut off inside SNR digits still gives its entry first.
      if (ph == PhSnrMore) add_entry();
      r = '0;
      r.kind = nmea_gsv_pkg::KindSummary;
      r.time_ms = ts_acc;
      r.entry_count = sent_entries;
      step_results.push_back(r);
      clear_sentence();
    end
    foreach (step_results[i]) begin
      step_results[i].last_of_run = (i == step_results.size() - 1);
      expected_results.push_back(step_results[i]);
    end
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    error_count++;
    $error("%s: expected %0d, got %0d", field, want, got);
  endtask

  // Both channels are observed at the falling edge, where every signal is settled
  // and equal to what the next rising edge will see. Prediction comes first, so the
  // expectations of a character are queued before any result beat is compared.
  always @(negedge clk) begin : observe_beats
    nmea_gsv_pkg::result_t got;
    nmea_gsv_pkg::result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) predict_char(in_char_in, in_end_of_sentence);
      if (out_valid && !out_stall) begin
        got = {out_kind, out_sat_id, out_sat_snr, out_time_ms, out_entry_count,
               out_last_of_run};
        if (expected_results.size() == 0) begin
          error_count++;
          $error("result beat with no expectation waiting");
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (got.kind !== want.kind)
            report_mismatch("kind", want.kind, got.kind);
          if (got.sat_id !== want.sat_id)
            report_mismatch("sat_id", want.sat_id, got.sat_id);
          if (got.sat_snr !== want.sat_snr)
            report_mismatch("sat_snr", want.sat_snr, got.sat_snr);
          if (got.time_ms !== want.time_ms)
            report_mismatch("time_ms", want.time_ms, got.time_ms);
          if (got.entry_count !== want.entry_count)
            report_mismatch("entry_count", want.entry_count, got.entry_count);
          if (got.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", want.last_of_run, got.last_of_run);
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count,
               expected_results.size());
      $display("testbench: errors");
      $finish;
    end
  end

  // One character beat: an optional gap, then valid held until the beat is taken.
  task automatic send_char(input logic [7:0] ch, input logic last);
    logic taken;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_char_in <= ch;
    in_end_of_sentence <= last;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    chars_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic add_digits(input int unsigned count);
    repeat (count) line_q.push_back(nmea_gsv_pkg::CharZero + 8'($urandom_range(9)));
  endtask

  // Sends the assembled line, marking its last character as the end of sentence.
  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) send_char(line_q[i], i == line_q.size() - 1);
    line_q.delete();
    lines_sent++;
  endtask

  task automatic send_text(input string s);
    add_text(s);
    send_line();
  endtask

  // Drops valid, waits for every expected result, then lets the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // One register transfer: a setup phase, then the access phase until pready.
  task automatic cfg_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    logic ready;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= MaxEntriesAddr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ready = pready;
      rdata = prdata;
      @(posedge clk);
    end while (!ready);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes max_entries with junk in the upper bits, then reads it back.
  task automatic set_max_entries(input logic [7:0] value);
    logic [31:0] rd;
    wait_idle();
    cfg_access(1'b1, {24'($urandom), value}, rd);
    entry_limit = value;
    limit_writes++;
    cfg_access(1'b0, 32'd0, rd);
    if (rd[7:0] !== value) report_mismatch("max_entries readback", value, rd[7:0]);
  endtask

  function automatic logic [7:0] pick_limit();
    case ($urandom_range(6))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd2;
      3:       return 8'd255;
      4:       return nmea_gsv_pkg::MaxEntriesReset;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // A mostly well-formed GSV sentence with random timestamp, count and groups.
  task automatic build_gsv_line();
    int unsigned cut;
    line_q.delete();
    add_digits($urandom_range(22));
    case ($urandom_range(5))
      0:       add_text("$GPG");
      1:       add_text("$GPRMC,1,2*");
      default: ;
    endcase
    add_text($urandom_range(9) == 0 ? "$GPGSA" : "$GPGSV");
    add_text(",");
    add_digits($urandom_range(1));
    add_text(",");
    add_digits($urandom_range(1));
    add_text(",");
    case ($urandom_range(9))
      0:       add_text("0");
      1:       ;
      2:       add_text("256");
      default: add_text($sformatf("%0d", $urandom_range(1, 20)));
    endcase
    repeat ($urandom_range(6)) begin
      add_text(",");
      case ($urandom_range(9))
        0:       add_text("0");
        1:       ;
        2:       add_text($sformatf("%0d", $urandom_range(256, 999)));
        default: add_text($sformatf("%0d", $urandom_range(1, 99)));
      endcase
      add_text(",");
      // Now and then the group breaks off at a checksum star.
      if ($urandom_range(19) == 0) add_text("*");
      else add_digits($urandom_range(2));
      add_text(",");
      add_digits($urandom_range(3));
      add_text(",");
      case ($urandom_range(9))
        0:       ;
        1:       add_text("255");
        2:       add_text($sformatf("%0d", $urandom_range(100, 999)));
        default: add_text($sformatf("%0d", $urandom_range(99)));
      endcase
    end
    case ($urandom_range(3))
      0:       ;
      1:       add_text("*");
      default: add_text($sformatf("*%02X", $urandom_range(255)));
    endcase
    if ($urandom_range(6) == 0) begin
      cut = $urandom_range(line_q.size() - 1);
      while (line_q.size() > cut + 1) void'(line_q.pop_back());
    end
  endtask

  task automatic build_noise_line();
    line_q.delete();
    repeat ($urandom_range(1, 30)) line_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic test_register_access();
    logic [31:0] rd;
    cfg_access(1'b0, 32'd0, rd);
    if (rd[7:0] !== nmea_gsv_pkg::MaxEntriesReset)
      report_mismatch("max_entries after reset", nmea_gsv_pkg::MaxEntriesReset, rd[7:0]);
    set_max_entries(8'd255);
    set_max_entries(nmea_gsv_pkg::MaxEntriesReset);
  endtask

  task automatic test_timestamp();
    // Largest 64-bit value, then one past it, wrapping to zero on its last digit.
    send_text("18446744073709551615,");
    send_text("18446744073709551616");
    // A one-character sentence with no timestamp at all.
    send_text("Z");
  endtask

  task automatic test_tag_search();
    // A partial tag restarted by a dollar sign, then a star during the header skip.
    send_text("7$GP$GPGSV,3,*,9,1,,,5");
    // A count of zero, plain and wrapped from 256, gives no entries.
    send_text("$GPGSV,1,1,0,5,,,9*");
    send_text("$GPGSV,1,1,256,5,,,9*");
  endtask

  task automatic test_satellite_groups();
    // Zero id dropped, wrapped id with SNR 255, an empty SNR, and a group broken
    // by a star, after which the rest of the line is ignored.
    send_text("42$GPGSV,2,1,8,0,1,2,40,300,5,6,255,12,,,,9,*,7,,,12");
    // End of sentence inside SNR digits, and right where the SNR field starts.
    send_text("$GPGSV,,,1,5,,,1");
    send_text("$GPGSV,,,1,6,,,");
    // A NUL character is just another non-digit closing the id.
    add_text("$GPGSV,,,1,8");
    line_q.push_back(8'h00);
    add_text(",,5*");
    send_line();
  endtask

  task automatic test_entry_limit();
    set_max_entries(8'd0);
    send_text("$GPGSV,,,2,1,,,5,2,,,6*");
    set_max_entries(8'd1);
    send_text("$GPGSV,,,2,1,,,5,2,,,6*");
    set_max_entries(8'd255);
    send_text("$GPGSV,,,2,1,,,5,2,,,6*");
    set_max_entries(nmea_gsv_pkg::MaxEntriesReset);
  endtask

  task automatic run_random_phase(input int send_pct, input int recv_pct,
                                  input int char_count);
    int stop_at;
    int pick;
    int lines;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    stop_at = chars_sent + char_count;
    lines = 0;
    while (chars_sent < stop_at) begin
      if (lines % LinesPerLimit == LinesPerLimit - 1) set_max_entries(pick_limit());
      pick = $urandom_range(99);
      if (pick < 15) build_noise_line();
      else build_gsv_line();
      send_line();
      lines++;
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(13, 60, RandomChars / 3);
    run_random_phase(60, 13, RandomChars / 3);
    run_random_phase(0, 0, RandomChars - 2 * (RandomChars / 3));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 13;
    recv_stall_pct = 60;
    test_register_access();
    test_timestamp();
    test_tag_search();
    test_satellite_groups();
    test_entry_limit();
    test_random_traffic();
    wait_idle();
    $display("covered %0d characters in %0d sentences, %0d result beats compared",
             chars_sent, lines_sent, results_checked);
    $display("max_entries written %0d times under three idling regimes", limit_writes);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
